FILE: hdl/lcbe_pkg.sv
// ----------------------------------------------------------------------------
// LED brightness estimator package
// Shared widths, codes, configuration and item types, and a helper function.
// ----------------------------------------------------------------------------
`default_nettype none

package lcbe_pkg;

    localparam int TIME_W = 64;
    localparam int VOLT_W = 24;
    localparam int THR_W = 23;
    localparam int COND_W = 20;
    localparam int CUR_W = 20;
    localparam int HALF_W = 40;
    localparam int INT_W = 10;
    localparam int ACC_W = 64;
    localparam int DV_W = 23;
    localparam int CUR_FRAC = 16;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W = 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [INT_W-1:0] INTENSITY_OFF = 10'd25;
    localparam logic [INT_W-1:0] INTENSITY_MAX = 10'd1023;
    localparam logic [15:0] GAMMA_SCALE = 16'd65025;

    localparam logic MODE_VOLTAGE = 1'b0;
    localparam logic MODE_FRAME = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD,
        REG_CONDUCTANCE,
        REG_MAX_CURRENT,
        REG_HALF_FRAME
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold_uv;
        logic [COND_W-1:0] conductance_q16;
        logic [CUR_W-1:0]  max_current_ua;
        logic [HALF_W-1:0] half_frame_ticks;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        threshold_uv:     23'd2400000,
        conductance_q16:  20'd109227,
        max_current_ua:   20'd30000,
        half_frame_ticks: 40'd8333333333
    };

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] time_ticks;
        logic [CUR_W-1:0]  current_ua;
        logic              running;
        logic              pause_debug;
    } item_t;

    typedef struct packed {
        logic             start;
        logic [ACC_W-1:0] dividend;
        logic [ACC_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_CHARGE,
        ST_DECIDE,
        ST_DIV_AVG,
        ST_SCALE,
        ST_XSTART,
        ST_DIV_X,
        ST_SQRT,
        ST_SQRT_END,
        ST_FINISH
    } back_state_t;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/lcbe_if.sv
// ----------------------------------------------------------------------------
// LED brightness estimator channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcbe_item_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [lcbe_pkg::TIME_W-1:0]       time_ticks;
    logic signed [lcbe_pkg::VOLT_W-1:0] volt_diff_uv;
    logic                              running;
    logic                              pause_debug;

    modport source (
        output valid, mode, time_ticks, volt_diff_uv, running, pause_debug,
        input  ready
    );

    modport sink (
        input  valid, mode, time_ticks, volt_diff_uv, running, pause_debug,
        output ready
    );
endinterface

interface lcbe_result_if;
    logic                         valid;
    logic                         ready;
    logic [lcbe_pkg::INT_W-1:0]   intensity;
    logic                         intensity_updated;
    logic [lcbe_pkg::CUR_W-1:0]   current_ua;

    modport source (
        output valid, intensity, intensity_updated, current_ua,
        input  ready
    );

    modport sink (
        input  valid, intensity, intensity_updated, current_ua,
        output ready
    );
endinterface

`default_nettype wire

FILE: hdl/lcbe_regs.sv
// ----------------------------------------------------------------------------
// LED brightness estimator register file
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbe_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lcbe_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lcbe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lcbe_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready,
    output lcbe_pkg::cfg_t                         cfg
);

    lcbe_pkg::cfg_t cfg_reg;
    lcbe_pkg::cfg_t cfg_next;
    lcbe_pkg::reg_idx_t idx;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;
    assign idx = lcbe_pkg::reg_idx_t'(
        paddr[lcbe_pkg::REG_IDX_LSB+lcbe_pkg::REG_IDX_W-1:lcbe_pkg::REG_IDX_LSB]);
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lcbe_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                lcbe_pkg::REG_THRESHOLD:
                    cfg_next.threshold_uv = pwdata[lcbe_pkg::THR_W-1:0];
                lcbe_pkg::REG_CONDUCTANCE:
                    cfg_next.conductance_q16 = pwdata[lcbe_pkg::COND_W-1:0];
                lcbe_pkg::REG_MAX_CURRENT:
                    cfg_next.max_current_ua = pwdata[lcbe_pkg::CUR_W-1:0];
                lcbe_pkg::REG_HALF_FRAME:
                    cfg_next.half_frame_ticks = pwdata[lcbe_pkg::HALF_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lcbe_pkg::REG_THRESHOLD:
                prdata = lcbe_pkg::APB_DATA_W'(cfg_reg.threshold_uv);
            lcbe_pkg::REG_CONDUCTANCE:
                prdata = lcbe_pkg::APB_DATA_W'(cfg_reg.conductance_q16);
            lcbe_pkg::REG_MAX_CURRENT:
                prdata = lcbe_pkg::APB_DATA_W'(cfg_reg.max_current_ua);
            lcbe_pkg::REG_HALF_FRAME:
                prdata = lcbe_pkg::APB_DATA_W'(cfg_reg.half_frame_ticks);
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/lcbe_front.sv
// ----------------------------------------------------------------------------
// LED brightness estimator front end
// Accepts input transactions, computes the diode current and queues the item.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbe_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lcbe_item_if.sink           item,
    input  wire lcbe_pkg::cfg_t cfg,
    input  wire logic           fifo_full,
    output logic                fifo_push,
    output lcbe_pkg::item_t     fifo_data
);

    localparam int PROD_W = lcbe_pkg::DV_W + lcbe_pkg::COND_W;
    localparam int CUR_TOP = lcbe_pkg::CUR_FRAC + lcbe_pkg::CUR_W;

    logic                              stage_valid_reg;
    logic                              stage_mode_reg;
    logic [lcbe_pkg::TIME_W-1:0]       stage_time_reg;
    logic [lcbe_pkg::DV_W-1:0]         stage_dv_reg;
    logic                              stage_running_reg;
    logic                              stage_pdebug_reg;

    logic                              accept;
    logic [lcbe_pkg::VOLT_W:0]         dv_full;
    logic                              dv_positive;
    logic [lcbe_pkg::DV_W-1:0]         dv_pos;
    logic [PROD_W-1:0]                 prod;
    logic                              cur_sat;
    logic [lcbe_pkg::CUR_W-1:0]        cur;

    assign fifo_push = stage_valid_reg && !fifo_full;
    assign item.ready = !stage_valid_reg || !fifo_full;
    assign accept = item.valid && item.ready;

    assign dv_full = {item.volt_diff_uv[lcbe_pkg::VOLT_W-1], item.volt_diff_uv}
                   - (lcbe_pkg::VOLT_W+1)'(cfg.threshold_uv);
    assign dv_positive = !dv_full[lcbe_pkg::VOLT_W] && (dv_full != '0);
    assign dv_pos = dv_positive ? dv_full[lcbe_pkg::DV_W-1:0] : '0;

    assign prod = PROD_W'(stage_dv_reg) * PROD_W'(cfg.conductance_q16);
    assign cur_sat = |prod[PROD_W-1:CUR_TOP];
    assign cur = cur_sat ? '1 : prod[CUR_TOP-1:lcbe_pkg::CUR_FRAC];

    always_comb
    begin
        fifo_data.mode = stage_mode_reg;
        fifo_data.time_ticks = stage_time_reg;
        fifo_data.current_ua = (stage_mode_reg == lcbe_pkg::MODE_VOLTAGE) ? cur : '0;
        fifo_data.running = stage_running_reg;
        fifo_data.pause_debug = stage_pdebug_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (fifo_push)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_mode_reg <= item.mode;
            stage_time_reg <= item.time_ticks;
            stage_dv_reg <= dv_pos;
            stage_running_reg <= item.running;
            stage_pdebug_reg <= item.pause_debug;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lcbe_fifo.sv
// ----------------------------------------------------------------------------
// LED brightness estimator item queue
// Short queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbe_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire lcbe_pkg::item_t wdata,
    output logic                 full,
    input  wire logic            pop,
    output lcbe_pkg::item_t      rdata,
    output logic                 empty
);

    localparam logic [lcbe_pkg::FIFO_PTR_W:0] FULL_COUNT =
        (lcbe_pkg::FIFO_PTR_W+1)'(lcbe_pkg::FIFO_DEPTH);

    lcbe_pkg::item_t                 mem_reg [lcbe_pkg::FIFO_DEPTH];
    logic [lcbe_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [lcbe_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [lcbe_pkg::FIFO_PTR_W:0]   count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full = (count_reg == FULL_COUNT);
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lcbe_div.sv
// ----------------------------------------------------------------------------
// LED brightness estimator divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbe_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lcbe_pkg::div_req_t req,
    output lcbe_pkg::div_rsp_t      rsp
);

    localparam int W = lcbe_pkg::ACC_W;
    localparam int CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     quot_reg;
    logic [W-1:0]     rem_reg;
    logic [W-1:0]     divisor_reg;

    logic [W:0]       rem_shift;
    logic             ge;
    logic [W:0]       diff;

    assign rem_shift = {rem_reg, quot_reg[W-1]};
    assign ge = rem_shift >= {1'b0, divisor_reg};
    assign diff = rem_shift - {1'b0, divisor_reg};

    assign rsp.done = done_reg;
    assign rsp.quotient = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[W-2:0], ge};
            rem_reg <= ge ? diff[W-1:0] : rem_shift[W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lcbe_back.sv
// ----------------------------------------------------------------------------
// LED brightness estimator back end
// Charge accumulation, averaging, brightness curve and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcbe_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lcbe_pkg::cfg_t     cfg,
    input  wire logic               fifo_empty,
    output logic                    fifo_pop,
    input  wire lcbe_pkg::item_t    fifo_data,
    output lcbe_pkg::div_req_t      div_req,
    input  wire lcbe_pkg::div_rsp_t div_rsp,
    lcbe_result_if.source           result
);

    localparam int ACC_W = lcbe_pkg::ACC_W;
    localparam int HALF = ACC_W / 2;
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = HALF;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int PART_W = lcbe_pkg::CUR_W + HALF;
    localparam int SCALED_W = 40;
    localparam int SQ_W = 20;
    localparam int SAT_SHIFT = 4;
    localparam int SUM_W = lcbe_pkg::INT_W + 2;
    localparam logic [SQ_W-1:0] SQRT_START = SQ_W'(1) << (SQ_W - 2);

    lcbe_pkg::back_state_t          state_reg, state_next;
    logic [lcbe_pkg::TIME_W-1:0]    previous_time_reg, previous_time_next;
    logic [lcbe_pkg::CUR_W-1:0]     present_current_reg, present_current_next;
    logic [ACC_W-1:0]               charge_total_reg, charge_total_next;
    logic [ACC_W-1:0]               elapsed_ticks_reg, elapsed_ticks_next;
    logic [lcbe_pkg::INT_W-1:0]     intensity_reg, intensity_next;
    logic                           updated_reg, updated_next;
    logic                           out_valid_reg, out_valid_next;

    lcbe_pkg::item_t                item_reg, item_next;
    logic [ACC_W-1:0]               period_reg, period_next;
    logic [PART_W-1:0]              lo_reg, lo_next;
    logic [PART_W-1:0]              hi_reg, hi_next;
    logic [ACC_W-1:0]               q_reg, q_next;
    logic [ACC_W-1:0]               avg_reg, avg_next;
    logic [SCALED_W-1:0]            scaled_reg, scaled_next;
    logic [SQ_W-1:0]                sqrt_x_reg, sqrt_x_next;
    logic [SQ_W-1:0]                root_reg, root_next;
    logic [SQ_W-1:0]                sqrt_bit_reg, sqrt_bit_next;
    logic [lcbe_pkg::INT_W-1:0]     out_intensity_reg, out_intensity_next;
    logic                           out_updated_reg, out_updated_next;
    logic [lcbe_pkg::CUR_W-1:0]     out_current_reg, out_current_next;

    logic [MUL_A_W-1:0]             mul_a;
    logic [MUL_B_W-1:0]             mul_b;
    logic [MUL_P_W-1:0]             mul_p;
    logic [PART_W:0]                upper;
    logic [SQ_W:0]                  trial;
    logic [SUM_W-1:0]               bright_sum;
    logic [lcbe_pkg::CUR_W-1:0]     max_eff;
    logic                           out_free;

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign upper = {1'b0, hi_reg} + (PART_W+1)'(lo_reg[PART_W-1:HALF]);
    assign trial = {1'b0, root_reg} + {1'b0, sqrt_bit_reg};
    assign bright_sum = SUM_W'(root_reg) + SUM_W'(lcbe_pkg::INTENSITY_OFF);
    assign max_eff = (cfg.max_current_ua == '0) ? lcbe_pkg::CUR_W'(1) : cfg.max_current_ua;
    assign out_free = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.intensity = out_intensity_reg;
    assign result.intensity_updated = out_updated_reg;
    assign result.current_ua = out_current_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcbe_pkg::ST_IDLE;
            previous_time_reg <= '0;
            present_current_reg <= '0;
            charge_total_reg <= '0;
            elapsed_ticks_reg <= '0;
            intensity_reg <= lcbe_pkg::INTENSITY_OFF;
            updated_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            previous_time_reg <= previous_time_next;
            present_current_reg <= present_current_next;
            charge_total_reg <= charge_total_next;
            elapsed_ticks_reg <= elapsed_ticks_next;
            intensity_reg <= intensity_next;
            updated_reg <= updated_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        period_reg <= period_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        q_reg <= q_next;
        avg_reg <= avg_next;
        scaled_reg <= scaled_next;
        sqrt_x_reg <= sqrt_x_next;
        root_reg <= root_next;
        sqrt_bit_reg <= sqrt_bit_next;
        out_intensity_reg <= out_intensity_next;
        out_updated_reg <= out_updated_next;
        out_current_reg <= out_current_next;
    end

    always_comb
    begin
        state_next = state_reg;
        previous_time_next = previous_time_reg;
        present_current_next = present_current_reg;
        charge_total_next = charge_total_reg;
        elapsed_ticks_next = elapsed_ticks_reg;
        intensity_next = intensity_reg;
        updated_next = updated_reg;
        out_valid_next = out_valid_reg;
        item_next = item_reg;
        period_next = period_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        q_next = q_reg;
        avg_next = avg_reg;
        scaled_next = scaled_reg;
        sqrt_x_next = sqrt_x_reg;
        root_next = root_reg;
        sqrt_bit_next = sqrt_bit_reg;
        out_intensity_next = out_intensity_reg;
        out_updated_next = out_updated_reg;
        out_current_next = out_current_reg;
        fifo_pop = 1'b0;
        div_req.start = 1'b0;
        div_req.dividend = charge_total_reg;
        div_req.divisor = elapsed_ticks_reg;
        mul_a = MUL_A_W'(present_current_reg);
        mul_b = period_reg[HALF-1:0];

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            lcbe_pkg::ST_IDLE:
            begin
                if (!fifo_empty)
                begin
                    fifo_pop = 1'b1;
                    item_next = fifo_data;
                    if (fifo_data.mode == lcbe_pkg::MODE_FRAME && !fifo_data.running)
                    begin
                        charge_total_next = '0;
                        elapsed_ticks_next = '0;
                        intensity_next = lcbe_pkg::INTENSITY_OFF;
                        updated_next = 1'b1;
                        state_next = lcbe_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = lcbe_pkg::ST_PERIOD;
                    end
                end
            end
            lcbe_pkg::ST_PERIOD:
            begin
                period_next = (item_reg.time_ticks >= previous_time_reg)
                            ? item_reg.time_ticks - previous_time_reg : '0;
                previous_time_next = item_reg.time_ticks;
                state_next = lcbe_pkg::ST_MUL_LO;
            end
            lcbe_pkg::ST_MUL_LO:
            begin
                lo_next = mul_p[PART_W-1:0];
                elapsed_ticks_next = lcbe_pkg::sat_add(elapsed_ticks_reg, period_reg);
                state_next = lcbe_pkg::ST_MUL_HI;
            end
            lcbe_pkg::ST_MUL_HI:
            begin
                mul_b = period_reg[ACC_W-1:HALF];
                hi_next = mul_p[PART_W-1:0];
                state_next = lcbe_pkg::ST_SUM;
            end
            lcbe_pkg::ST_SUM:
            begin
                q_next = (|upper[PART_W:HALF]) ? '1 : {upper[HALF-1:0], lo_reg[HALF-1:0]};
                state_next = lcbe_pkg::ST_CHARGE;
            end
            lcbe_pkg::ST_CHARGE:
            begin
                charge_total_next = lcbe_pkg::sat_add(charge_total_reg, q_reg);
                state_next = lcbe_pkg::ST_DECIDE;
            end
            lcbe_pkg::ST_DECIDE:
            begin
                if (item_reg.mode == lcbe_pkg::MODE_VOLTAGE)
                begin
                    present_current_next = item_reg.current_ua;
                    updated_next = 1'b0;
                    state_next = lcbe_pkg::ST_FINISH;
                end
                else if (item_reg.pause_debug)
                begin
                    avg_next = ACC_W'(present_current_reg);
                    state_next = lcbe_pkg::ST_SCALE;
                end
                else if (elapsed_ticks_reg > ACC_W'(cfg.half_frame_ticks))
                begin
                    div_req.start = 1'b1;
                    state_next = lcbe_pkg::ST_DIV_AVG;
                end
                else
                begin
                    updated_next = 1'b0;
                    state_next = lcbe_pkg::ST_FINISH;
                end
            end
            lcbe_pkg::ST_DIV_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next = div_rsp.quotient;
                    charge_total_next = '0;
                    elapsed_ticks_next = '0;
                    state_next = lcbe_pkg::ST_SCALE;
                end
            end
            lcbe_pkg::ST_SCALE:
            begin
                // At sixteen times full scale or more the curve is already saturated.
                if (avg_reg >= (ACC_W'(max_eff) << SAT_SHIFT))
                begin
                    intensity_next = lcbe_pkg::INTENSITY_MAX;
                    updated_next = 1'b1;
                    state_next = lcbe_pkg::ST_FINISH;
                end
                else
                begin
                    mul_a = avg_reg[MUL_A_W-1:0];
                    mul_b = MUL_B_W'(lcbe_pkg::GAMMA_SCALE);
                    scaled_next = mul_p[SCALED_W-1:0];
                    state_next = lcbe_pkg::ST_XSTART;
                end
            end
            lcbe_pkg::ST_XSTART:
            begin
                div_req.start = 1'b1;
                div_req.dividend = ACC_W'(scaled_reg);
                div_req.divisor = ACC_W'(max_eff);
                state_next = lcbe_pkg::ST_DIV_X;
            end
            lcbe_pkg::ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    sqrt_x_next = div_rsp.quotient[SQ_W-1:0];
                    root_next = '0;
                    sqrt_bit_next = SQRT_START;
                    state_next = lcbe_pkg::ST_SQRT;
                end
            end
            lcbe_pkg::ST_SQRT:
            begin
                if ({1'b0, sqrt_x_reg} >= trial)
                begin
                    sqrt_x_next = sqrt_x_reg - trial[SQ_W-1:0];
                    root_next = (root_reg >> 1) + sqrt_bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                sqrt_bit_next = sqrt_bit_reg >> 2;
                if (sqrt_bit_reg == SQ_W'(1))
                begin
                    state_next = lcbe_pkg::ST_SQRT_END;
                end
            end
            lcbe_pkg::ST_SQRT_END:
            begin
                intensity_next = (bright_sum > SUM_W'(lcbe_pkg::INTENSITY_MAX))
                               ? lcbe_pkg::INTENSITY_MAX
                               : bright_sum[lcbe_pkg::INT_W-1:0];
                updated_next = 1'b1;
                state_next = lcbe_pkg::ST_FINISH;
            end
            lcbe_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_intensity_next = intensity_reg;
                    out_updated_next = updated_reg;
                    out_current_next = present_current_reg;
                    state_next = lcbe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcbe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/led_current_brightness_estimator.sv
// ----------------------------------------------------------------------------
// LED current and brightness estimator
// A voltage event passes the front-end stage register and the back-end states
// IDLE, PERIOD, MUL_LO, MUL_HI, SUM, CHARGE, DECIDE and FINISH; the sequencer
// takes a new event only after it finishes the last. A frame update computing
// the average makes two 64-step passes through the shared divider and a 10-step
// root. Reset is asynchronous: totals clear and intensity returns to 25.
// ----------------------------------------------------------------------------
`default_nettype none

module led_current_brightness_estimator (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    lcbe_item_if.sink                              item,
    lcbe_result_if.source                          result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lcbe_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [lcbe_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lcbe_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    lcbe_pkg::cfg_t     cfg;
    logic               fifo_push;
    logic               fifo_full;
    logic               fifo_pop;
    logic               fifo_empty;
    lcbe_pkg::item_t    fifo_wdata;
    lcbe_pkg::item_t    fifo_rdata;
    lcbe_pkg::div_req_t div_req;
    lcbe_pkg::div_rsp_t div_rsp;

    lcbe_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lcbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .fifo_full (fifo_full),
        .fifo_push (fifo_push),
        .fifo_data (fifo_wdata)
    );

    lcbe_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fifo_push),
        .wdata (fifo_wdata),
        .full  (fifo_full),
        .pop   (fifo_pop),
        .rdata (fifo_rdata),
        .empty (fifo_empty)
    );

    lcbe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lcbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fifo_empty (fifo_empty),
        .fifo_pop   (fifo_pop),
        .fifo_data  (fifo_rdata),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .result     (result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_push && fifo_full))
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_pop && fifo_empty))
        else $error("Queue read while empty.");

    a_intensity_floor: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.intensity >= lcbe_pkg::INTENSITY_OFF))
        else $error("Result intensity below the off level.");

endmodule

`default_nettype wire
